### src/rqs_pkg.sv
// shared types and codes for the ready queue scheduler
`timescale 1ns / 1ps
package rqs_pkg;

    localparam int PID_W  = 5;
    localparam int CPU_W  = 3;
    localparam int ACT_W  = 3;
    localparam int KIND_W = 2;
    localparam int SLICE_W = 8;
    localparam int REQ_PRIO_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int MODE_W = 2;
    localparam int ACTIVE_W = 4;

    localparam logic [ACT_W-1:0] ACT_WAKE_UP   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PREEMPT   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_YIELD     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TERMINATE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_IDLE      = 3'd4;

    localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PREEMPT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOTHING  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FCFS     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RR       = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRIORITY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SLICE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CPUS = 2'd2;

    // per-cell load controls
    typedef struct packed {
        logic take_new;
        logic take_prev;
        logic take_next;
    } cell_ctl_t;

endpackage

### src/rqs_if.sv
// event and result channel interfaces
`timescale 1ns / 1ps
interface rqs_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [2:0] cpu_index;
    logic [4:0] process_id;
    logic [7:0] priority_req;
    modport source (output valid, output action, output cpu_index, output process_id,
                    output priority_req, input ready);
    modport sink (input valid, input action, input cpu_index, input process_id,
                  input priority_req, output ready);
endinterface

interface rqs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [2:0] target_cpu;
    logic       dispatched_valid;
    logic [4:0] dispatched_id;
    logic [7:0] slice_out;
    logic       overflow;
    modport source (output valid, output result_kind, output target_cpu,
                    output dispatched_valid, output dispatched_id, output slice_out,
                    output overflow, input ready);
    modport sink (input valid, input result_kind, input target_cpu,
                  input dispatched_valid, input dispatched_id, input slice_out,
                  input overflow, output ready);
endinterface

### src/rqs_queue_cell.sv
// one slot of the ready queue shift row
`timescale 1ns / 1ps
module rqs_queue_cell #(
    parameter int PRIO_BITS = 8
) (
    input  logic                        clk,
    input  rqs_pkg::cell_ctl_t          ctl,
    input  logic [rqs_pkg::PID_W-1:0]   new_pid,
    input  logic [PRIO_BITS-1:0]        new_prio,
    input  logic [rqs_pkg::PID_W-1:0]   prev_pid,
    input  logic [PRIO_BITS-1:0]        prev_prio,
    input  logic [rqs_pkg::PID_W-1:0]   next_pid,
    input  logic [PRIO_BITS-1:0]        next_prio,
    output logic [rqs_pkg::PID_W-1:0]   pid,
    output logic [PRIO_BITS-1:0]        prio,
    output logic                        gt
);
    import rqs_pkg::*;

    logic [PID_W-1:0]     pid_reg;
    logic [PRIO_BITS-1:0] prio_reg;

    always_ff @(posedge clk)
    begin
        priority if (ctl.take_new)
        begin
            pid_reg  <= new_pid;
            prio_reg <= new_prio;
        end
        else if (ctl.take_prev)
        begin
            pid_reg  <= prev_pid;
            prio_reg <= prev_prio;
        end
        else if (ctl.take_next)
        begin
            pid_reg  <= next_pid;
            prio_reg <= next_prio;
        end
    end

    // entry is strictly less urgent than the newcomer
    assign gt   = prio_reg > new_prio;
    assign pid  = pid_reg;
    assign prio = prio_reg;

endmodule

### src/multi_cpu_ready_queue_scheduler.sv
// top level of the multi-cpu ready queue scheduler
`timescale 1ns / 1ps
// usage:
//   events enter on ev (action, cpu_index, process_id, priority_req) and
//   each transfer yields exactly one result on res. the block works on one
//   event at a time: ev.ready is high only while no event is in flight.
//   configuration (mode, time_slice, active_cpus) is written on the plain
//   write port at index 0, 1, 2 while the block is idle.
// steps from event transfer to result valid:
//   yield, terminate, idle: dispatch step, result register
//   preempt: requeue then dispatch when the cpu was busy, else dispatch only
//   wake-up: insert step; in priority mode, when the queue was not full, then a
//   cpu scan, one running-table entry a cycle, over up to active_cpus cpus (at most
//   MAX_CPUS), ending early at an idle cpu; ignored events: result register only
// a new event is taken only after the previous result has transferred
// the ready queue is a row of QUEUE_DEPTH cells; a dequeue moves every cell at once,
// each from its next neighbor; an insert moves the cells above the insert point
// reset: queue empty, all cpus idle, mode fcfs, slice 0, one active cpu
// receiver stall: the result is held in its register until res transfers;
// no new event is taken meanwhile
module multi_cpu_ready_queue_scheduler #(
    parameter int MAX_CPUS    = 8,
    parameter int QUEUE_DEPTH = 32,
    parameter int PRIO_BITS   = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rqs_in_if.sink                         ev,
    rqs_out_if.source                      res,
    input  logic                           write_en,
    input  logic [rqs_pkg::CFG_IDX_W-1:0]  write_index,
    input  logic [rqs_pkg::CFG_DATA_W-1:0] write_data
);
    import rqs_pkg::*;

    localparam int CW   = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int SW   = $clog2(MAX_CPUS + 1);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INS  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_DISP = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg;
    logic [SLICE_W-1:0]  slice_reg;
    logic [ACTIVE_W-1:0] active_reg;
    logic [CNTW-1:0]     count_reg, count_next;

    // latched event
    logic [ACT_W-1:0]     act_reg, act_next;
    logic [CW-1:0]        cpu_reg, cpu_next;
    logic [PID_W-1:0]     ins_pid_reg, ins_pid_next;
    logic [PRIO_BITS-1:0] ins_prio_reg, ins_prio_next;

    // cpu scan
    logic [SW-1:0]        scan_reg, scan_next;
    logic [PRIO_BITS-1:0] maxp_reg, maxp_next;
    logic [CW-1:0]        victim_reg, victim_next;

    // running table: one valid bit per cpu, reset clears it
    logic [MAX_CPUS-1:0]  run_valid_reg;
    logic [PID_W-1:0]     run_pid_reg  [MAX_CPUS];
    logic [PRIO_BITS-1:0] run_prio_reg [MAX_CPUS];
    logic                 tbl_we, tbl_valid;

    // result register
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [CPU_W-1:0]   tgt_reg, tgt_next;
    logic               dv_reg, dv_next;
    logic [PID_W-1:0]   did_reg, did_next;
    logic [SLICE_W-1:0] so_reg, so_next;
    logic               ovf_reg, ovf_next;

    // queue row
    cell_ctl_t            ctl [QUEUE_DEPTH];
    logic [PID_W-1:0]     cell_pid  [QUEUE_DEPTH];
    logic [PRIO_BITS-1:0] cell_prio [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_gt;
    logic [QUEUE_DEPTH:0] ins_flags, ins_low, ins_ge;
    logic                 ins_en, deq_en, q_full, q_empty;
    logic                 ev_xfer, cpu_ok;
    logic [SW-1:0]        scan_limit;

    assign ev_xfer = ev.valid && ev.ready;
    assign q_full  = count_reg == CNTW'(QUEUE_DEPTH);
    assign q_empty = count_reg == '0;
    assign cpu_ok  = int'(ev.cpu_index) < MAX_CPUS;
    assign scan_limit = (int'(active_reg) < MAX_CPUS) ? SW'(active_reg) : SW'(MAX_CPUS);

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic [PID_W-1:0]     p_pid, n_pid;
            logic [PRIO_BITS-1:0] p_prio, n_prio;
            if (gi == 0)
            begin : g_first
                assign p_pid  = '0;
                assign p_prio = '0;
            end
            else
            begin : g_mid
                assign p_pid  = cell_pid[gi-1];
                assign p_prio = cell_prio[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign n_pid  = '0;
                assign n_prio = '0;
            end
            else
            begin : g_inner
                assign n_pid  = cell_pid[gi+1];
                assign n_prio = cell_prio[gi+1];
            end
            rqs_queue_cell #(.PRIO_BITS(PRIO_BITS)) u_cell (
                .clk       (clk),
                .ctl       (ctl[gi]),
                .new_pid   (ins_pid_reg),
                .new_prio  (ins_prio_reg),
                .prev_pid  (p_pid),
                .prev_prio (p_prio),
                .next_pid  (n_pid),
                .next_prio (n_prio),
                .pid       (cell_pid[gi]),
                .prio      (cell_prio[gi]),
                .gt        (cell_gt[gi])
            );
        end
    endgenerate

    // insert position: first occupied cell less urgent than the newcomer
    // (priority mode only), else the tail; ins_low marks it, ins_ge marks it and above
    always_comb
    begin
        ins_flags = (QUEUE_DEPTH + 1)'(1) << count_reg;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (cell_gt[i] && (i < int'(count_reg)) && (mode_reg == MODE_PRIORITY))
            begin
                ins_flags[i] = 1'b1;
            end
        end
        ins_low = ins_flags & (~ins_flags + 1'b1);
        ins_ge  = ~(ins_low - 1'b1);
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            ctl[i].take_new  = ins_en && ins_low[i];
            ctl[i].take_prev = ins_en && ins_ge[i] && !ins_low[i];
            ctl[i].take_next = deq_en;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        act_next      = act_reg;
        cpu_next      = cpu_reg;
        ins_pid_next  = ins_pid_reg;
        ins_prio_next = ins_prio_reg;
        scan_next     = scan_reg;
        maxp_next     = maxp_reg;
        victim_next   = victim_reg;
        kind_next     = kind_reg;
        tgt_next      = tgt_reg;
        dv_next       = dv_reg;
        did_next      = did_reg;
        so_next       = so_reg;
        ovf_next      = ovf_reg;
        ins_en        = 1'b0;
        deq_en        = 1'b0;
        tbl_we        = 1'b0;
        tbl_valid     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (ev_xfer)
                begin
                    act_next  = ev.action;
                    cpu_next  = CW'(ev.cpu_index);
                    kind_next = KIND_NOTHING;
                    tgt_next  = '0;
                    dv_next   = 1'b0;
                    did_next  = '0;
                    so_next   = '0;
                    ovf_next  = 1'b0;
                    if (ev.action == ACT_WAKE_UP)
                    begin
                        ins_pid_next  = ev.process_id;
                        ins_prio_next = PRIO_BITS'(ev.priority_req);
                        state_next    = ST_INS;
                    end
                    else if (ev.action > ACT_IDLE || !cpu_ok)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (ev.action == ACT_PREEMPT && run_valid_reg[CW'(ev.cpu_index)])
                    begin
                        // requeue the running process first
                        ins_pid_next  = run_pid_reg[CW'(ev.cpu_index)];
                        ins_prio_next = run_prio_reg[CW'(ev.cpu_index)];
                        state_next    = ST_INS;
                    end
                    else
                    begin
                        state_next = ST_DISP;
                    end
                end
            end
            ST_INS:
            begin
                if (q_full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    ins_en     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                if (act_reg == ACT_PREEMPT)
                begin
                    state_next = ST_DISP;
                end
                else if (!q_full && mode_reg == MODE_PRIORITY)
                begin
                    scan_next   = '0;
                    maxp_next   = '0;
                    victim_next = '0;
                    state_next  = ST_SCAN;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_SCAN:
            begin
                if (scan_reg >= scan_limit)
                begin
                    if (maxp_reg > ins_prio_reg)
                    begin
                        kind_next = KIND_PREEMPT;
                        tgt_next  = CPU_W'(victim_reg);
                    end
                    state_next = ST_OUT;
                end
                else if (!run_valid_reg[scan_reg[CW-1:0]])
                begin
                    // an idle cpu will pick the newcomer up
                    state_next = ST_OUT;
                end
                else
                begin
                    if (run_prio_reg[scan_reg[CW-1:0]] > maxp_reg)
                    begin
                        maxp_next   = run_prio_reg[scan_reg[CW-1:0]];
                        victim_next = scan_reg[CW-1:0];
                    end
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_DISP:
            begin
                kind_next = KIND_DISPATCH;
                tgt_next  = CPU_W'(cpu_reg);
                so_next   = slice_reg;
                tbl_we    = 1'b1;
                if (q_empty)
                begin
                    dv_next  = 1'b0;
                    did_next = '0;
                end
                else
                begin
                    tbl_valid  = 1'b1;
                    deq_en     = 1'b1;
                    count_next = count_reg - 1'b1;
                    dv_next    = 1'b1;
                    did_next   = cell_pid[0];
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (res.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            run_valid_reg <= '0;
            mode_reg      <= MODE_FCFS;
            slice_reg     <= '0;
            active_reg    <= ACTIVE_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (tbl_we)
            begin
                run_valid_reg[cpu_reg] <= tbl_valid;
            end
            if (write_en)
            begin
                unique case (write_index)
                    CFG_MODE:        mode_reg   <= MODE_W'(write_data);
                    CFG_TIME_SLICE:  slice_reg  <= SLICE_W'(write_data);
                    CFG_ACTIVE_CPUS: active_reg <= ACTIVE_W'(write_data);
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        cpu_reg      <= cpu_next;
        ins_pid_reg  <= ins_pid_next;
        ins_prio_reg <= ins_prio_next;
        scan_reg     <= scan_next;
        maxp_reg     <= maxp_next;
        victim_reg   <= victim_next;
        kind_reg     <= kind_next;
        tgt_reg      <= tgt_next;
        dv_reg       <= dv_next;
        did_reg      <= did_next;
        so_reg       <= so_next;
        ovf_reg      <= ovf_next;
        if (tbl_we)
        begin
            run_pid_reg[cpu_reg]  <= tbl_valid ? cell_pid[0]  : '0;
            run_prio_reg[cpu_reg] <= tbl_valid ? cell_prio[0] : '0;
        end
    end

    assign ev.ready             = state_reg == ST_IDLE;
    assign res.valid            = state_reg == ST_OUT;
    assign res.result_kind      = kind_reg;
    assign res.target_cpu       = tgt_reg;
    assign res.dispatched_valid = dv_reg;
    assign res.dispatched_id    = did_reg;
    assign res.slice_out        = so_reg;
    assign res.overflow         = ovf_reg;

endmodule
